>>> rtl/core/lht_pkg.sv
// Shared types and constants for the lease handle table.
// No dependencies; used by lht_cell, lease_handle_table and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package lht_pkg;

  localparam int SLOTS     = 64;
  localparam int ID_W      = 32;
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int CAP_W     = 7;
  localparam int REV_W     = 32;
  localparam int STAT_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY = 2'd0,
    CFG_CLOSED   = 2'd1,
    CFG_REVISION = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_CLOSED    = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_EXHAUSTED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'b01,
    ST_RESOLVE = 2'b10
  } state_e;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic            cmp_en;
    logic            app_en;
    logic            shift_en;
    logic [ID_W-1:0] key;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/lht_cell.sv
// One slot of the lease table: holds an ID, compares it against the search key
// and takes its upper neighbor's ID when the row closes a gap. Uses lht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lht_cell
  import lht_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cell_ctrl_t      ctrl_i,
  input  wire logic            active_i,
  input  wire logic            tail_i,
  input  wire logic [ID_W-1:0] next_entry_i,
  input  wire logic            hit_i,
  output      logic            hit_o,
  output      logic [ID_W-1:0] entry_o
);

  logic [ID_W-1:0] entry_q, entry_d;
  logic            match_q, match_d;

  // The hit flag ripples upward: every active cell at or above the matching
  // slot sees it set and pulls its neighbor down by one place.
  assign hit_o   = hit_i | match_q;
  assign entry_o = entry_q;

  always_comb begin
    match_d = match_q;
    if (ctrl_i.cmp_en) begin
      match_d = active_i && (entry_q == ctrl_i.key);
    end
  end

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.app_en && tail_i) begin
      entry_d = ctrl_i.key;
    end else if (ctrl_i.shift_en && hit_o && active_i) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

>>> rtl/core/lease_handle_table.sv
// Top level of the lease handle table: controller, configuration registers,
// result registers and the row of lht_cell slots. Uses lht_pkg.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  command  | start / busy               | command_i, lease_id_i
//  config   | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//  result   | done_o (one-cycle strobe)  | status_o, granted_id_o, revision_o,
//           |                            | active_count_o, acquired_total_o,
//           |                            | retired_total_o
//
// An acquire and a release of ID 0 show their result in the cycle after the
// transfer. On a release of a nonzero ID all slots compare in parallel, then
// in ST_RESOLVE the hit ripples through the row and the slots above it shift
// down by one; busy is high in ST_RESOLVE. Reset clears the counters, totals,
// closed flag and revision and sets the capacity to 64; slot contents are not
// cleared. The receiver cannot stall, so no result is ever held.
`timescale 1ns / 1ps
`default_nettype none

module lease_handle_table
  import lht_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output      logic                 busy,
  input  wire logic                 command_i,
  input  wire logic [ID_W-1:0]      lease_id_i,
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  output      logic                 done_o,
  output      logic [STAT_W-1:0]    status_o,
  output      logic [ID_W-1:0]      granted_id_o,
  output      logic [REV_W-1:0]     revision_o,
  output      logic [CNT_W-1:0]     active_count_o,
  output      logic [31:0]          acquired_total_o,
  output      logic [31:0]          retired_total_o
);

  localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  state_e          state_q, state_d;
  logic [CAP_W-1:0] cap_q;
  logic             closed_q;
  logic [REV_W-1:0] rev_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [ID_W-1:0]  last_id_q, last_id_d;
  logic [31:0]      grant_tot_q, grant_tot_d;
  logic [31:0]      retire_tot_q, retire_tot_d;
  logic             done_q, done_d;
  status_e          status_q, status_d;
  logic [ID_W-1:0]  granted_q, granted_d;

  cell_ctrl_t       ctrl;
  logic             accept;
  logic [LIM_W-1:0] cap_ext, slots_ext, limit;
  logic             full;
  logic [ID_W-1:0]  next_id;

  logic [SLOTS-1:0] active, tail, hit_chain;
  logic [ID_W-1:0]  entry [SLOTS];

  assign accept      = start && !busy;
  assign busy        = (state_q == ST_RESOLVE);
  assign cfg_ready_o = 1'b1;

  assign cap_ext   = LIM_W'(cap_q);
  assign slots_ext = LIM_W'(SLOTS);
  assign limit     = (cap_ext >= slots_ext) ? slots_ext : cap_ext;
  assign full      = LIM_W'(count_q) >= limit;
  assign next_id   = last_id_q + ID_W'(1);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    last_id_d    = last_id_q;
    grant_tot_d  = grant_tot_q;
    retire_tot_d = retire_tot_q;
    done_d       = 1'b0;
    status_d     = STAT_OK;
    granted_d    = '0;
    ctrl.cmp_en   = 1'b0;
    ctrl.app_en   = 1'b0;
    ctrl.shift_en = 1'b0;
    ctrl.key      = lease_id_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i == CMD_ACQUIRE) begin
            done_d   = 1'b1;
            ctrl.key = next_id;
            if (closed_q) begin
              status_d = STAT_CLOSED;
            end else if (full) begin
              status_d = STAT_FULL;
            end else if (last_id_q == '1) begin
              status_d = STAT_EXHAUSTED;
            end else begin
              ctrl.app_en = 1'b1;
              last_id_d   = next_id;
              granted_d   = next_id;
              count_d     = count_q + CNT_W'(1);
              grant_tot_d = grant_tot_q + 32'd1;
            end
          end else if (lease_id_i == '0) begin
            done_d = 1'b1;
          end else begin
            ctrl.cmp_en = 1'b1;
            state_d     = ST_RESOLVE;
          end
        end
      end
      ST_RESOLVE: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
        if (hit_chain[SLOTS-1]) begin
          ctrl.shift_en = 1'b1;
          count_d       = count_q - CNT_W'(1);
          retire_tot_d  = retire_tot_q + 32'd1;
        end else begin
          status_d = STAT_NOT_FOUND;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign active[i] = CNT_W'(i) < count_q;
    assign tail[i]   = CNT_W'(i) == count_q;

    lht_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .active_i     (active[i]),
      .tail_i       (tail[i]),
      .next_entry_i ((i == SLOTS - 1) ? '0 : entry[(i + 1) % SLOTS]),
      .hit_i        ((i == 0) ? 1'b0 : hit_chain[(i + SLOTS - 1) % SLOTS]),
      .hit_o        (hit_chain[i]),
      .entry_o      (entry[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cap_q        <= CAP_W'(64);
      closed_q     <= 1'b0;
      rev_q        <= '0;
      count_q      <= '0;
      last_id_q    <= '0;
      grant_tot_q  <= '0;
      retire_tot_q <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      last_id_q    <= last_id_d;
      grant_tot_q  <= grant_tot_d;
      retire_tot_q <= retire_tot_d;
      done_q       <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_CAPACITY: cap_q    <= cfg_data_i[CAP_W-1:0];
          CFG_CLOSED:   closed_q <= cfg_data_i[0];
          CFG_REVISION: rev_q    <= cfg_data_i[REV_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    granted_q <= granted_d;
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign granted_id_o     = granted_q;
  assign revision_o       = rev_q;
  assign active_count_o   = count_q;
  assign acquired_total_o = grant_tot_q;
  assign retired_total_o  = retire_tot_q;

  // A release search always resolves and reports in the following cycle.
  a_resolve_reports : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESOLVE) |=> done_o)
    else $error("release search did not report a result");

  // An acquire transfer reports on the very next cycle.
  a_acquire_reports : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == CMD_ACQUIRE) |=> done_o)
    else $error("acquire did not report a result");

  // A release that misses leaves the active count untouched.
  a_miss_keeps_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_NOT_FOUND) |-> (count_q == $past(count_q)))
    else $error("active count changed on a failed release");

  // The active count never exceeds the number of slots.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (LIM_W'(count_q) <= slots_ext))
    else $error("active count above slot count");

endmodule

`default_nettype wire

>>> tb/sv/lease_handle_table_tb.sv
// Self-checking testbench for lease_handle_table: a directed table, then random phases
// under several register settings, all checked against a lease-set predictor in this file.
// Depends on lht_pkg and lease_handle_table only.
`timescale 1ns / 1ps

module lease_handle_table_tb
  import lht_pkg::*;
();

  localparam int IDLE_LIMIT = 2000;
  localparam int N_PHASES   = 12;
  localparam int PHASE_OPS  = 145;
  localparam int DRAIN_WAIT = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    status_e          status;
    logic [ID_W-1:0]  granted;
    logic [REV_W-1:0] revision;
    logic [CNT_W-1:0] count;
    logic [31:0]      acq_total;
    logic [31:0]      ret_total;
  } lease_result_t;

  typedef enum int {ROW_OP, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    cmd_e                  cmd;
    logic [CFG_IDX_W-1:0]  idx;
    logic [31:0]           data;
    bit                    typed;
    status_e               status;
    logic [ID_W-1:0]       granted;
    logic [CNT_W-1:0]      count;
  } lease_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 command_i = 1'b0;
  logic [ID_W-1:0]      lease_id_i = '0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 done_o;
  logic [STAT_W-1:0]    status_o;
  logic [ID_W-1:0]      granted_id_o;
  logic [REV_W-1:0]     revision_o;
  logic [CNT_W-1:0]     active_count_o;
  logic [31:0]          acquired_total_o;
  logic [31:0]          retired_total_o;

  // Predictor copy of the lease set, the totals and the registers.
  logic [ID_W-1:0]  held_ids [SLOTS];
  int unsigned      held_cnt = 0;
  logic [ID_W-1:0]  newest_id = '0;
  logic [31:0]      grant_total = '0;
  logic [31:0]      retire_total = '0;
  logic [CAP_W-1:0] cap_reg = 7'd64;
  logic             closed_reg = 1'b0;
  logic [REV_W-1:0] rev_reg = '0;

  lease_result_t pending_results[$];
  lease_row_t    lease_rows[$];
  int            mismatch_cnt = 0;
  int            idle_cycles = 0;

  lease_handle_table u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .lease_id_i      (lease_id_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .granted_id_o    (granted_id_o),
    .revision_o      (revision_o),
    .active_count_o  (active_count_o),
    .acquired_total_o(acquired_total_o),
    .retired_total_o (retired_total_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic lease_result_t predict_lease_op(cmd_e cmd, logic [ID_W-1:0] id);
    lease_result_t r;
    int unsigned   limit;
    int            hit;
    r.status  = STAT_OK;
    r.granted = '0;
    limit = (cap_reg < SLOTS) ? cap_reg : SLOTS;
    if (cmd == CMD_ACQUIRE) begin
      if (closed_reg) begin
        r.status = STAT_CLOSED;
      end else if (held_cnt >= limit) begin
        r.status = STAT_FULL;
      end else if (newest_id == '1) begin
        r.status = STAT_EXHAUSTED;
      end else begin
        newest_id = newest_id + 1'b1;
        held_ids[held_cnt] = newest_id;
        held_cnt++;
        r.granted = newest_id;
        grant_total++;
      end
    end else if (id != '0) begin
      hit = -1;
      for (int i = 0; i < held_cnt; i++) begin
        if (hit < 0 && held_ids[i] == id) hit = i;
      end
      if (hit < 0) begin
        r.status = STAT_NOT_FOUND;
      end else begin
        // Only set membership is visible, so the slot order does not matter here.
        held_ids[hit] = held_ids[held_cnt-1];
        held_cnt--;
        retire_total++;
      end
    end
    r.revision  = rev_reg;
    r.count     = held_cnt[CNT_W-1:0];
    r.acq_total = grant_total;
    r.ret_total = retire_total;
    return r;
  endfunction

  // Leaves start high so that back-to-back commands keep it asserted.
  task automatic issue_op(input cmd_e cmd, input logic [ID_W-1:0] id,
                          output lease_result_t res);
    start      <= 1'b1;
    command_i  <= cmd;
    lease_id_i <= id;
    do @(posedge clk_i); while (busy);
    res = predict_lease_op(cmd, id);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CAPACITY: cap_reg = data[CAP_W-1:0];
      CFG_CLOSED:   closed_reg = data[0];
      CFG_REVISION: rev_reg = data;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic row_op(input cmd_e cmd, input logic [ID_W-1:0] id);
    lease_row_t row;
    row.kind  = ROW_OP;
    row.cmd   = cmd;
    row.data  = id;
    row.typed = 1'b0;
    lease_rows.push_back(row);
  endtask

  task automatic row_chk(input cmd_e cmd, input logic [ID_W-1:0] id, input status_e st,
                         input logic [ID_W-1:0] gid, input logic [CNT_W-1:0] cnt);
    lease_row_t row;
    row.kind    = ROW_OP;
    row.cmd     = cmd;
    row.data    = id;
    row.typed   = 1'b1;
    row.status  = st;
    row.granted = gid;
    row.count   = cnt;
    lease_rows.push_back(row);
  endtask

  task automatic row_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    lease_row_t row;
    row.kind = ROW_REG;
    row.idx  = idx;
    row.data = data;
    lease_rows.push_back(row);
  endtask

  task automatic run_phase(input int n_ops, input int acq_pct, input bit gaps);
    lease_result_t res;
    cmd_e          cmd;
    logic [ID_W-1:0] id;
    int            burst_left;
    int            pick;
    burst_left = $urandom_range(1, 24);
    for (int n = 0; n < n_ops; n++) begin
      if (n == n_ops / 2) wait_drained();
      if (gaps && burst_left == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      id   = $urandom();
      cmd  = ($urandom_range(0, 99) < acq_pct) ? CMD_ACQUIRE : CMD_RELEASE;
      pick = $urandom_range(0, 99);
      if (cmd == CMD_RELEASE) begin
        // Mostly live leases; the rest are no-ops, stale, unissued or arbitrary IDs.
        if (pick < 70 && held_cnt > 0) id = held_ids[$urandom_range(0, held_cnt - 1)];
        else if (pick < 78) id = '0;
        else if (pick < 86 && newest_id != '0) id = $urandom_range(1, newest_id);
        else if (pick < 93) id = newest_id + $urandom_range(1, 3);
      end
      issue_op(cmd, id, res);
      pending_results.push_back(res);
    end
  endtask

  // Result checker: one expectation per done strobe, oldest first.
  always @(posedge clk_i) begin
    lease_result_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        if (mismatch_cnt < 10) $display("ERROR: result with nothing expected, status %0d",
                                        status_o);
        mismatch_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        if (status_o !== exp_r.status || granted_id_o !== exp_r.granted ||
            revision_o !== exp_r.revision || active_count_o !== exp_r.count ||
            acquired_total_o !== exp_r.acq_total || retired_total_o !== exp_r.ret_total)
        begin
          if (mismatch_cnt < 10) begin
            $display("ERROR: expected st=%0d gid=%h rev=%h cnt=%0d acq=%0d ret=%0d",
                     exp_r.status, exp_r.granted, exp_r.revision, exp_r.count,
                     exp_r.acq_total, exp_r.ret_total);
            $display("       actual   st=%0d gid=%h rev=%h cnt=%0d acq=%0d ret=%0d",
                     status_o, granted_id_o, revision_o, active_count_o,
                     acquired_total_o, retired_total_o);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    lease_result_t res;
    lease_row_t    row;
    logic [CAP_W-1:0] cap;
    int            acq_pct;

    row_chk(CMD_RELEASE, 32'h0,        STAT_OK,        '0, 7'd0);
    row_chk(CMD_RELEASE, 32'hFFFF_FFFF, STAT_NOT_FOUND, '0, 7'd0);
    row_chk(CMD_RELEASE, 32'h1,        STAT_NOT_FOUND, '0, 7'd0);
    row_chk(CMD_ACQUIRE, 32'h0,        STAT_OK,        32'd1, 7'd1);
    row_chk(CMD_ACQUIRE, 32'hFFFF_FFFF, STAT_OK,        32'd2, 7'd2);
    row_op (CMD_ACQUIRE, 32'h0);
    row_chk(CMD_RELEASE, 32'd2,        STAT_OK,        '0, 7'd2);
    row_chk(CMD_RELEASE, 32'd2,        STAT_NOT_FOUND, '0, 7'd2);
    row_reg(CFG_REVISION, 32'hFFFF_FFFF);
    row_reg(CFG_CAPACITY, 32'hABCD_EF02);
    row_chk(CMD_ACQUIRE, 32'h0,        STAT_FULL,      '0, 7'd2);
    row_chk(CMD_RELEASE, 32'd1,        STAT_OK,        '0, 7'd1);
    row_chk(CMD_ACQUIRE, 32'h0,        STAT_OK,        32'd4, 7'd2);
    row_reg(CFG_CLOSED, 32'h0000_0001);
    row_chk(CMD_ACQUIRE, 32'h0,        STAT_CLOSED,    '0, 7'd2);
    // Releases are still served while the plane is closed.
    row_chk(CMD_RELEASE, 32'd3,        STAT_OK,        '0, 7'd1);
    row_reg(CFG_CAPACITY, 32'h0000_0000);
    row_chk(CMD_ACQUIRE, 32'h0,        STAT_CLOSED,    '0, 7'd1);
    row_reg(CFG_CLOSED, 32'hFFFF_FFFE);
    row_chk(CMD_ACQUIRE, 32'h0,        STAT_FULL,      '0, 7'd1);
    row_chk(CMD_RELEASE, 32'd4,        STAT_OK,        '0, 7'd0);
    row_chk(CMD_ACQUIRE, 32'h0,        STAT_FULL,      '0, 7'd0);
    row_reg(CFG_CAPACITY, 32'hFFFF_FFFF);
    row_reg(CFG_REVISION, 32'h0);
    row_chk(CMD_ACQUIRE, 32'h0,        STAT_OK,        32'd5, 7'd1);
    row_reg(CFG_SPARE, 32'h0000_0001);
    row_chk(CMD_ACQUIRE, 32'h0,        STAT_OK,        32'd6, 7'd2);
    row_op (CMD_RELEASE, 32'd6);
    row_chk(CMD_RELEASE, 32'd5,        STAT_OK,        '0, 7'd0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (lease_rows[i]) begin
      row = lease_rows[i];
      if (row.kind == ROW_REG) begin
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk_i);
        write_reg(row.idx, row.data);
        cfg_valid_i <= 1'b0;
      end else begin
        issue_op(row.cmd, row.data, res);
        if (row.typed) begin
          res.status  = row.status;
          res.granted = row.granted;
          res.count   = row.count;
        end
        pending_results.push_back(res);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0, 6, 7: cap = 7'd64;
        1, 11:   cap = 7'd127;
        2:       cap = CAP_W'($urandom_range(65, 126));
        3:       cap = 7'd1;
        4:       cap = 7'd0;
        5:       cap = CAP_W'($urandom_range(2, 63));
        10:      cap = 7'd3;
        default: cap = CAP_W'($urandom_range(0, 127));
      endcase
      case (p)
        0, 7:    acq_pct = 88;
        2:       acq_pct = 20;
        5:       acq_pct = 70;
        9:       acq_pct = 30;
        default: acq_pct = 50;
      endcase
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clk_i);
      write_reg(CFG_CAPACITY, ($urandom() & 32'hFFFF_FF80) | cap);
      write_reg(CFG_CLOSED, ($urandom() & 32'hFFFF_FFFE) | ((p == 6 || p == 9) ? 1 : 0));
      write_reg(CFG_REVISION, (p == 3) ? 32'hFFFF_FFFF : (p == 7) ? 32'h0 : $urandom());
      cfg_valid_i <= 1'b0;
      run_phase(PHASE_OPS, acq_pct, !(p == 8 || p == 11));
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> lease_handle_table.f
rtl/core/lht_pkg.sv
rtl/core/lht_cell.sv
rtl/core/lease_handle_table.sv
tb/sv/lease_handle_table_tb.sv
